>>> sv/upd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder package
// Character codes and hex digit helpers for the front end, and the queued
// result bundle that the front end, the queue and the back end share.
// ---------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_UPA   = 8'h41;

  // Result bytes caused by one input beat, in emission order.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;   // one to three bytes are valid
    logic       last;  // the beat closed its string
  } upd_bundle_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } upd_q_status_t;

  // True when the character is 0-9, a-f or A-F.
  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= CH_ZERO) && (c <= CH_ZERO + 8'd9)) ||
        ((c >= CH_LOWA) && (c <= CH_LOWA + 8'd5)) ||
        ((c >= CH_UPA)  && (c <= CH_UPA  + 8'd5));
    return r;
  endfunction

  // Nibble value of a hex character; meaningless for other characters.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CH_LOWA) && (c <= CH_LOWA + 8'd5)) begin
      v = c - CH_LOWA + 8'd10;
    end else if ((c >= CH_UPA) && (c <= CH_UPA + 8'd5)) begin
      v = c - CH_UPA + 8'd10;
    end else begin
      v = c - CH_ZERO;
    end
    return v[3:0];
  endfunction

endpackage

>>> sv/upd_enc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoded byte channel
// Valid/ready channel that carries one raw byte of an encoded string.
// ---------------------------------------------------------------------------
interface upd_enc_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_last;

  modport source (output valid, output in_byte, output string_last, input ready);
  modport sink   (input valid, input in_byte, input string_last, output ready);
endinterface

>>> sv/upd_dec_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decoded byte channel
// Valid/ready channel that carries one decoded byte and its end markers.
// ---------------------------------------------------------------------------
interface upd_dec_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last,
                  output string_done, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input string_done, output ready);
endinterface

>>> sv/upd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder front end
// Accepts encoded bytes, tracks the escape phase and forms the bundle of
// result bytes that each beat causes.
// ---------------------------------------------------------------------------
module upd_front (
  input  logic                  clk,
  input  logic                  rst,
  upd_enc_if.sink               enc,
  input  upd_pkg::upd_q_status_t q_stat,
  output logic                  push,
  output upd_pkg::upd_bundle_t  push_data
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic [7:0] held_next;
  logic       accept;
  logic [7:0] res [3];
  logic [1:0] n;
  logic       b_hex;

  assign enc.ready = !q_stat.full;
  assign accept    = enc.valid && enc.ready;
  assign b_hex     = upd_pkg::is_hex(enc.in_byte);

  // Classify the beat against the current phase and collect its results.
  always_comb begin
    logic rescan;
    rescan     = 1'b0;
    phase_next = PH_IDLE;
    held_next  = held_digit;
    n          = 2'd0;
    res[0]     = '0;
    res[1]     = '0;
    res[2]     = '0;

    case (phase)
      PH_PCT: begin
        if (b_hex) begin
          held_next  = enc.in_byte;
          phase_next = PH_DIGIT;
        end else begin
          res[n] = upd_pkg::CH_PCT;
          n      = n + 2'd1;
          rescan = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          res[n] = {upd_pkg::hex_nibble(held_digit), upd_pkg::hex_nibble(enc.in_byte)};
          n      = n + 2'd1;
        end else begin
          res[n] = upd_pkg::CH_PCT;
          n      = n + 2'd1;
          res[n] = held_digit;
          n      = n + 2'd1;
          rescan = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // Ordinary handling of a byte outside an escape.
    if (rescan) begin
      if (enc.in_byte == upd_pkg::CH_PLUS) begin
        res[n] = upd_pkg::CH_SPACE;
        n      = n + 2'd1;
      end else if (enc.in_byte == upd_pkg::CH_PCT) begin
        phase_next = PH_PCT;
      end else begin
        res[n] = enc.in_byte;
        n      = n + 2'd1;
      end
    end

    // The end of a string flushes a pending escape literally.
    if (enc.string_last) begin
      if (phase_next == PH_PCT) begin
        res[n] = upd_pkg::CH_PCT;
        n      = n + 2'd1;
      end else if (phase_next == PH_DIGIT) begin
        res[n] = upd_pkg::CH_PCT;
        n      = n + 2'd1;
        res[n] = held_next;
        n      = n + 2'd1;
      end
      phase_next = PH_IDLE;
    end
  end

  assign push           = accept && (n != 2'd0);
  assign push_data.b0   = res[0];
  assign push_data.b1   = res[1];
  assign push_data.b2   = res[2];
  assign push_data.cnt  = n;
  assign push_data.last = enc.string_last;

  // Escape state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_next;
    end
  end

endmodule

>>> sv/upd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder bundle queue
// Short register queue of result bundles between the front and back ends.
// ---------------------------------------------------------------------------
module upd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  upd_pkg::upd_bundle_t   push_data,
  input  logic                   pop,
  output upd_pkg::upd_bundle_t   head,
  output upd_pkg::upd_q_status_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_LVL  = CW'(DEPTH);

  upd_pkg::upd_bundle_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] level;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (level == FULL_LVL);
  assign q_stat.empty = (level == '0);

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        level <= level + CW'(1);
      end else if (pop && !push) begin
        level <= level - CW'(1);
      end
    end
  end

endmodule

>>> sv/upd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder back end
// Walks the bundle at the head of the queue and sends its bytes one beat at
// a time, marking the final byte of each bundle and of each string.
// ---------------------------------------------------------------------------
module upd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  upd_pkg::upd_bundle_t   head,
  input  upd_pkg::upd_q_status_t q_stat,
  output logic                   pop,
  upd_dec_if.source              dec
);

  logic [1:0] idx;
  logic       final_byte;
  logic       accept;

  assign final_byte = (idx == head.cnt - 2'd1);
  assign accept     = dec.valid && dec.ready;
  assign pop        = accept && final_byte;

  // Present the selected byte of the head bundle.
  always_comb begin
    case (idx)
      2'd0:    dec.out_byte = head.b0;
      2'd1:    dec.out_byte = head.b1;
      default: dec.out_byte = head.b2;
    endcase
  end

  assign dec.valid       = !q_stat.empty;
  assign dec.run_last    = final_byte;
  assign dec.string_done = final_byte && head.last;

  // Byte index within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept) begin
      idx <= final_byte ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

>>> sv/url_percent_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of URL-encoded strings: '+' to space, %XX escapes to
// the byte they spell, broken escapes emitted literally.
// ---------------------------------------------------------------------------
//
//   Port   Direction  Beat carries
//   -----  ---------  ---------------------------------------------
//   enc    sink       in_byte, string_last (one raw byte)
//   dec    source     out_byte, run_last, string_done (one result)
//
// An encoded byte is taken while the queue has room; its zero to three
// result bytes leave one per cycle from the queue head while the receiver
// is ready, so a string of plain bytes runs at one byte per cycle when
// neither channel stalls, and a broken escape adds extra bytes at the output.
// The input stalls only when the DEPTH-entry bundle queue is full.
// Reset is synchronous; it empties the queue and returns to the idle phase.
//
module url_percent_decoder_unit #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  upd_enc_if.sink   enc,
  upd_dec_if.source dec
);

  logic                   push;
  logic                   pop;
  upd_pkg::upd_bundle_t   push_data;
  upd_pkg::upd_bundle_t   head;
  upd_pkg::upd_q_status_t q_stat;

  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .enc       (enc),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  upd_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  upd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .dec    (dec)
  );

  // The final beat of a string always leaves at least one result queued.
  a_last_yields : assert property (@(posedge clk) disable iff (rst)
    enc.valid && enc.ready && enc.string_last |=> !q_stat.empty)
    else $error("string end left no result in the queue");

  // A bundle is only retired from a non-empty queue.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("bundle retired from an empty queue");

  // Queued bundles never hold zero bytes.
  a_bundle_count : assert property (@(posedge clk) disable iff (rst)
    push |-> push_data.cnt != 2'd0)
    else $error("empty bundle written to the queue");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// URL percent decoder testbench
// Feeds encoded strings to the decoder: a short directed set of escapes,
// broken escapes and hex boundaries, then random strings built mostly from
// well-formed tokens. A scoreboard predicts every decoded beat from its own
// model of the escape phase and checks each one in order. Both channels
// stall at random.
// ---------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 120;
  localparam int TAIL_CYCLES    = 40;

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_DIGIT} escape_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } decoded_t;

  // Scoreboard: predicts the decoded beats of each encoded byte and checks
  // the beats that leave the block against them in order.
  class decode_scoreboard;
    escape_phase_t phase;
    logic [7:0]    held;
    decoded_t      run_q[$];
    decoded_t      expected_q[$];
    int            errors;
    int            reported;
    int            items_seen;
    int            strings_seen;
    int            results_seen;
    int            broken_seen;

    function new();
      phase        = PH_IDLE;
      held         = 8'h00;
      errors       = 0;
      reported     = 0;
      items_seen   = 0;
      strings_seen = 0;
      results_seen = 0;
      broken_seen  = 0;
    endfunction

    // Value of a hex digit character, 16 when it is not one.
    function int digit_value(logic [7:0] c);
      if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_ZERO + 8'd9) begin
        return c - upd_pkg::CH_ZERO;
      end
      if (c >= upd_pkg::CH_LOWA && c <= upd_pkg::CH_LOWA + 8'd5) begin
        return c - upd_pkg::CH_LOWA + 10;
      end
      if (c >= upd_pkg::CH_UPA && c <= upd_pkg::CH_UPA + 8'd5) begin
        return c - upd_pkg::CH_UPA + 10;
      end
      return 16;
    endfunction

    function void emit_byte(logic [7:0] b);
      decoded_t r;
      r.out_byte    = b;
      r.run_last    = 1'b0;
      r.string_done = 1'b0;
      run_q.push_back(r);
    endfunction

    // Handling of a byte outside any escape.
    function void scan_plain(logic [7:0] b);
      if (b == upd_pkg::CH_PLUS) begin
        emit_byte(upd_pkg::CH_SPACE);
      end else if (b == upd_pkg::CH_PCT) begin
        phase = PH_PCT;
      end else begin
        emit_byte(b);
      end
    endfunction

    function void note_encoded(logic [7:0] b, logic last);
      int         dv;
      int         hi;
      logic [7:0] value;
      dv = digit_value(b);
      run_q.delete();
      items_seen++;
      case (phase)
        PH_PCT: begin
          if (dv < 16) begin
            held  = b;
            phase = PH_DIGIT;
          end else begin
            // The escape breaks: the percent goes out and the byte is rescanned.
            broken_seen++;
            emit_byte(upd_pkg::CH_PCT);
            phase = PH_IDLE;
            scan_plain(b);
          end
        end
        PH_DIGIT: begin
          if (dv < 16) begin
            hi    = digit_value(held);
            value = {hi[3:0], dv[3:0]};
            emit_byte(value);
            phase = PH_IDLE;
          end else begin
            broken_seen++;
            emit_byte(upd_pkg::CH_PCT);
            emit_byte(held);
            phase = PH_IDLE;
            scan_plain(b);
          end
        end
        default: begin
          phase = PH_IDLE;
          scan_plain(b);
        end
      endcase
      // The last byte of a string flushes a pending escape literally.
      if (last) begin
        strings_seen++;
        if (phase == PH_PCT) begin
          emit_byte(upd_pkg::CH_PCT);
        end else if (phase == PH_DIGIT) begin
          emit_byte(upd_pkg::CH_PCT);
          emit_byte(held);
        end
        phase = PH_IDLE;
      end
      if (run_q.size() > 0) begin
        run_q[run_q.size() - 1].run_last    = 1'b1;
        run_q[run_q.size() - 1].string_done = last;
      end
      foreach (run_q[i]) begin
        expected_q.push_back(run_q[i]);
      end
    endfunction

    function void check_decoded(logic [7:0] ob, logic rl, logic sd);
      decoded_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected beat: byte %02h run_last %0b string_done %0b",
                   ob, rl, sd);
        end
        return;
      end
      want = expected_q.pop_front();
      if (want.out_byte !== ob || want.run_last !== rl || want.string_done !== sd) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("beat %0d: expected byte %02h run_last %0b string_done %0b, %s",
                   results_seen, want.out_byte, want.run_last, want.string_done,
                   $sformatf("got %02h %0b %0b", ob, rl, sd));
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  bit               calm = 1'b0;
  int               idle_cycles = 0;
  decode_scoreboard sb;

  upd_enc_if enc_ch ();
  upd_dec_if dec_ch ();

  url_percent_decoder_unit u_dut (
    .clk (clk),
    .rst (rst),
    .enc (enc_ch),
    .dec (dec_ch)
  );

  always #5 clk = ~clk;

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (enc_ch.valid && enc_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // A random hex digit character, either case.
  function automatic logic [7:0] pick_hex();
    int idx;
    idx = $urandom_range(0, 21);
    if (idx < 10) begin
      return upd_pkg::CH_ZERO + 8'(idx);
    end else if (idx < 16) begin
      return upd_pkg::CH_LOWA + 8'(idx - 10);
    end
    return upd_pkg::CH_UPA + 8'(idx - 16);
  endfunction

  // Offers one encoded byte after a random gap and waits for its beat.
  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      enc_ch.valid <= 1'b0;
    end
    @(negedge clk);
    enc_ch.valid       <= 1'b1;
    enc_ch.in_byte     <= b;
    enc_ch.string_last <= last;
    do @(posedge clk); while (!(enc_ch.valid && enc_ch.ready));
    sb.note_encoded(b, last);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1);
    end
  endtask

  // Withdraws the offered byte and waits until every predicted beat is out.
  task automatic wait_drained();
    @(negedge clk);
    enc_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Receiver: takes decoded beats after random stalls and checks each one.
  initial begin
    int gap;
    dec_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
        @(negedge clk);
        dec_ch.ready <= 1'b0;
      end
      @(negedge clk);
      dec_ch.ready <= 1'b1;
      do @(posedge clk); while (!(dec_ch.valid && dec_ch.ready));
      sb.check_decoded(dec_ch.out_byte, dec_ch.run_last, dec_ch.string_done);
    end
  end

  // Main sequence: reset, directed strings, then random strings.
  initial begin
    logic [7:0] txt[$];
    int         kind;
    int         n_tok;
    int         sent;
    bit         paused;
    sb                 = new();
    enc_ch.valid       = 1'b0;
    enc_ch.in_byte     = 8'h00;
    enc_ch.string_last = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // NUL and the top byte pass through unchanged.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // Good escapes with the range-end digits 0, 9, F and a.
    send_str("%0F%a9");
    // Broken escapes on the characters next to the digit ranges.
    send_str("%/%A:");
    send_item(upd_pkg::CH_PCT, 1'b0);
    send_item(8'h60, 1'b0);
    send_str("+%@");
    // A breaking percent opens a new escape of its own.
    send_str("%G%%g");
    // Pending escapes flushed at the end of the string.
    send_str("%9%");
    send_str("%");
    send_str("%f");

    // Let everything drain before the random part.
    wait_drained();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      txt.delete();
      n_tok = $urandom_range(1, 8);
      repeat (n_tok) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2: txt.push_back(8'($urandom_range(0, 255)));
          3: txt.push_back(upd_pkg::CH_PLUS);
          4, 5, 6: begin
            txt.push_back(upd_pkg::CH_PCT);
            txt.push_back(pick_hex());
            txt.push_back(pick_hex());
          end
          7: begin
            txt.push_back(upd_pkg::CH_PCT);
            txt.push_back(8'($urandom_range(0, 255)));
          end
          8: begin
            txt.push_back(upd_pkg::CH_PCT);
            txt.push_back(pick_hex());
            txt.push_back(8'($urandom_range(0, 255)));
          end
          default: txt.push_back(upd_pkg::CH_PCT);
        endcase
      end
      foreach (txt[i]) begin
        send_item(txt[i], i == txt.size() - 1);
      end
      sent += txt.size();
      // Halfway through, the sender holds off until the output has caught up.
      if (sent >= RANDOM_ITEMS / 2 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
    @(negedge clk);
    enc_ch.valid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected beats never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    $display("Decoded %0d encoded bytes in %0d strings into %0d beats.",
             sb.items_seen, sb.strings_seen, sb.results_seen);
    $display("Broken escapes seen: %0d; mismatches: %0d.", sb.broken_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
